FILE: src/skf_pkg.sv
// Shared types and constants for the scalar Kalman filter.
// Holds the mode and register codes, field widths and reset values.
// No dependencies.
package skf_pkg;

    // Fractional bits of estimate, variance and noise values.
    localparam int FRAC_BITS = 16;

    localparam int VAL_W  = 32;
    localparam int GAIN_W = 17;
    localparam int CFG_IDX_W = 2;

    // Gain of one in Q1.16.
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);

    localparam logic [VAL_W-1:0] VAL_ONE = VAL_W'(64'd1 << FRAC_BITS);
    localparam logic [VAL_W-1:0] Q_RESET = VAL_W'((64'd655 << FRAC_BITS) >> 16);

    // Operation carried with each request.
    typedef enum logic [1:0] {
        MODE_PROCESS = 2'd0,
        MODE_PREDICT = 2'd1,
        MODE_UPDATE  = 2'd2,
        MODE_RESTART = 2'd3
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROCESS_NOISE     = 2'd0,
        REG_MEASUREMENT_NOISE = 2'd1,
        REG_INITIAL_ESTIMATE  = 2'd2,
        REG_INITIAL_VARIANCE  = 2'd3
    } cfg_index_t;

endpackage

FILE: src/skf_mul.sv
// Shared multiplier of the scalar Kalman filter: 17-bit unsigned factor times
// an 18-bit signed slice, product registered. Depends on nothing.
module skf_mul
(
    input  logic                clk,
    input  logic [16:0]         a,
    input  logic signed [17:0]  b,
    output logic signed [35:0]  p
);

    logic signed [35:0] p_next;

    always_comb
    begin
        p_next = $signed({1'b0, a}) * b;
    end

    always_ff @(posedge clk)
    begin
        p <= p_next;
    end

endmodule

FILE: src/scalar_kalman_filter.sv
// Top level of the scalar Kalman filter (random-walk model, fixed point).
// Uses skf_pkg and the shared multiplier skf_mul.
//
// One-dimensional Kalman filter on signed Q16.16 values. Each request on the
// slave stream carries a mode in tuser and a measurement in tdata; each one
// yields exactly one result on the master stream with the estimate, the last
// gain (Q1.16, 65536 = one) and the error variance after the step. Modes:
// predict then update, predict only, update only, restart from the initial
// registers. Requests are taken one at a time; s_axis_tready is high only
// while the sequencer is idle. A zero gain denominator cuts the update short:
// the gain is set to zero and the division and multiplier passes are skipped.
// The update time is set by the restoring divider, one quotient bit per cycle
// for 17 gain bits, plus two passes through the single 18x18 multiplier (gain
// times residual, variance times one minus gain), each through the states
// S_MLO, S_MHI and S_MACC. A finished result sits in an output register, so
// the next request can be taken while it waits; the sequencer only holds at
// its last step if the previous result has not yet been taken. Configuration
// writes are registered and must only be issued while the block is idle.
module scalar_kalman_filter
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write port
    input  logic        cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0] cfg_data,

    // Request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] measurement
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode

    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata    // [31:0] estimate, [48:32] gain,
                                        // [80:49] variance, [87:81] zero
);

    localparam int DIV_STEPS = skf_pkg::GAIN_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int OUT_W     = 2 * skf_pkg::VAL_W + skf_pkg::GAIN_W;

    // Sequencer states, one-hot.
    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_PRED = 10'b00_0000_0010,
        S_DEN  = 10'b00_0000_0100,
        S_DIV  = 10'b00_0000_1000,
        S_MLO  = 10'b00_0001_0000,
        S_MHI  = 10'b00_0010_0000,
        S_MACC = 10'b00_0100_0000,
        S_EST  = 10'b00_1000_0000,
        S_VAR  = 10'b01_0000_0000,
        S_DONE = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [31:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] init_est_reg, init_est_next;
    logic [31:0] init_var_reg, init_var_next;

    // Filter state
    logic signed [31:0] est_reg, est_next;
    logic [31:0]        var_reg, var_next;
    logic [16:0]        gain_reg, gain_next;

    // Working registers of the current request
    skf_pkg::mode_t     mode_reg, mode_next;
    logic signed [31:0] z_reg, z_next;
    logic [32:0]        den_reg, den_next;
    logic [33:0]        rem_reg, rem_next;
    logic [16:0]        quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic signed [33:0] resid_reg, resid_next;
    logic [16:0]        mul_a_reg, mul_a_next;
    logic signed [33:0] mul_b_reg, mul_b_next;
    logic signed [50:0] acc_reg, acc_next;
    logic               phase_reg, phase_next;   // 0: estimate pass, 1: variance pass

    // Result register
    logic [OUT_W-1:0]   out_data_reg, out_data_next;
    logic               out_valid_reg, out_valid_next;

    // Datapath helpers
    logic               in_accept;
    logic [32:0]        pred_sum;
    logic [32:0]        den_sum;
    logic signed [34:0] div_trial;
    logic               div_bit;
    logic [33:0]        div_keep;
    logic [16:0]        div_quo;
    logic signed [17:0] mul_b_slice;
    logic signed [35:0] mul_p;
    logic signed [50:0] mul_p_ext;
    logic signed [50:0] acc_round;
    logic signed [34:0] delta;
    logic signed [35:0] est_sum;

    skf_mul u_mul
    (
        .clk (clk),
        .a   (mul_a_reg),
        .b   (mul_b_slice),
        .p   (mul_p)
    );

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(88 - OUT_W){1'b0}}, out_data_reg};

    always_comb
    begin
        // Saturating predict and the gain denominator
        pred_sum = {1'b0, var_reg} + {1'b0, q_reg};
        den_sum  = {1'b0, var_reg} + {1'b0, r_reg};

        // One restoring division step
        div_trial = $signed({1'b0, rem_reg}) - $signed({2'b00, den_reg});
        div_bit   = ~div_trial[34];
        div_keep  = div_bit ? div_trial[33:0] : rem_reg;
        div_quo   = {quo_reg[15:0], div_bit};

        // Low slice unsigned, high slice signed
        mul_b_slice = (state_reg == S_MHI) ? {mul_b_reg[33], mul_b_reg[33:17]}
                                           : {1'b0, mul_b_reg[16:0]};
        mul_p_ext   = {{15{mul_p[35]}}, mul_p};

        // Round to nearest, ties up, then the saturating estimate add
        acc_round = acc_reg + 51'sd32768;
        delta     = acc_round[50:16];
        est_sum   = {{4{est_reg[31]}}, est_reg} + {delta[34], delta};
    end

    always_comb
    begin
        state_next     = state_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        init_est_next  = init_est_reg;
        init_var_next  = init_var_reg;
        est_next       = est_reg;
        var_next       = var_reg;
        gain_next      = gain_reg;
        mode_next      = mode_reg;
        z_next         = z_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        resid_next     = resid_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        acc_next       = acc_reg;
        phase_next     = phase_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        if (cfg_we)
        begin
            unique case (skf_pkg::cfg_index_t'(cfg_index))
                skf_pkg::REG_PROCESS_NOISE:     q_next        = cfg_data;
                skf_pkg::REG_MEASUREMENT_NOISE: r_next        = cfg_data;
                skf_pkg::REG_INITIAL_ESTIMATE:  init_est_next = cfg_data;
                skf_pkg::REG_INITIAL_VARIANCE:  init_var_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    mode_next = skf_pkg::mode_t'(s_axis_tuser);
                    z_next    = s_axis_tdata;
                    unique case (skf_pkg::mode_t'(s_axis_tuser))
                        skf_pkg::MODE_PROCESS,
                        skf_pkg::MODE_PREDICT: state_next = S_PRED;
                        skf_pkg::MODE_UPDATE:  state_next = S_DEN;
                        skf_pkg::MODE_RESTART:
                        begin
                            est_next   = init_est_reg;
                            var_next   = init_var_reg;
                            gain_next  = '0;
                            state_next = S_DONE;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end

            S_PRED:
            begin
                var_next   = pred_sum[32] ? '1 : pred_sum[31:0];
                state_next = (mode_reg == skf_pkg::MODE_PREDICT) ? S_DONE : S_DEN;
            end

            S_DEN:
            begin
                den_next   = den_sum;
                rem_next   = {2'b00, var_reg};
                quo_next   = '0;
                cnt_next   = CNT_W'(DIV_STEPS - 1);
                resid_next = {{2{z_reg[31]}}, z_reg} - {{2{est_reg[31]}}, est_reg};
                if (den_sum == '0)
                begin
                    // Nothing to divide by: drop the gain, keep the rest
                    gain_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                quo_next = div_quo;
                rem_next = {div_keep[32:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    mul_a_next = div_quo;
                    mul_b_next = resid_reg;
                    phase_next = 1'b0;
                    state_next = S_MLO;
                end
            end

            S_MLO:
            begin
                state_next = S_MHI;
            end

            S_MHI:
            begin
                acc_next   = mul_p_ext;
                state_next = S_MACC;
            end

            S_MACC:
            begin
                acc_next   = acc_reg + (mul_p_ext <<< 17);
                state_next = phase_reg ? S_VAR : S_EST;
            end

            S_EST:
            begin
                if (est_sum[35:31] != {5{est_sum[35]}})
                    est_next = est_sum[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                else
                    est_next = est_sum[31:0];
                mul_a_next = skf_pkg::GAIN_ONE - quo_reg;
                mul_b_next = {2'b00, var_reg};
                phase_next = 1'b1;
                state_next = S_MLO;
            end

            S_VAR:
            begin
                var_next   = acc_round[47:16];
                gain_next  = quo_reg;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // Hold until the previous result has been taken
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_next  = {var_reg, gain_reg, est_reg};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
            q_reg         <= skf_pkg::Q_RESET;
            r_reg         <= skf_pkg::VAL_ONE;
            init_est_reg  <= '0;
            init_var_reg  <= skf_pkg::VAL_ONE;
            est_reg       <= '0;
            var_reg       <= skf_pkg::VAL_ONE;
            gain_reg      <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            q_reg         <= q_next;
            r_reg         <= r_next;
            init_est_reg  <= init_est_next;
            init_var_reg  <= init_var_next;
            est_reg       <= est_next;
            var_reg       <= var_next;
            gain_reg      <= gain_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        z_reg        <= z_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        resid_reg    <= resid_next;
        mul_a_reg    <= mul_a_next;
        mul_b_reg    <= mul_b_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

endmodule
